/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/tlvrsp_pkg.sv */
// ---------------------------------------------------------------------------
// TLV record stream parser package
// Item types, parse phases, tag decode and sizing constants.
// ---------------------------------------------------------------------------
package tlvrsp_pkg;

  localparam int STORE_BYTES = 256;
  localparam int POS_W       = $clog2(STORE_BYTES + 1);
  localparam int USED_W      = 10;
  localparam int IDX_W       = 9;
  localparam int KIND_W      = 3;

  localparam logic [7:0] TAG_MAC1    = 8'h01;
  localparam logic [7:0] TAG_MAC2    = 8'h02;
  localparam logic [7:0] TAG_SW_ID   = 8'h03;
  localparam logic [7:0] TAG_BKLIGHT = 8'h04;
  localparam logic [7:0] TAG_DISPLAY = 8'h10;
  localparam logic [7:0] TAG_LOGO    = 8'h11;

  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MAC1    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MAC2    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SW_ID   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BKLIGHT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DISPLAY = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LOGO    = 3'd6;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_VAL  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] record_kind;
    logic [IDX_W-1:0]  byte_index;
    logic [7:0]        byte_out;
    logic              kept;
    logic              done_res;
    logic [USED_W-1:0] used_size;
  } out_item_t;

  function automatic logic [KIND_W-1:0] kind_of_tag(input logic [7:0] tag);
    logic [KIND_W-1:0] k;
    case (tag)
      TAG_MAC1:    k = KIND_MAC1;
      TAG_MAC2:    k = KIND_MAC2;
      TAG_SW_ID:   k = KIND_SW_ID;
      TAG_BKLIGHT: k = KIND_BKLIGHT;
      TAG_DISPLAY: k = KIND_DISPLAY;
      TAG_LOGO:    k = KIND_LOGO;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/tlv_record_stream_parser_unit.sv */
// ---------------------------------------------------------------------------
// TLV record stream parser unit
// Walks a tag-length-value byte stream and labels each byte with its record.
// ---------------------------------------------------------------------------
// channel  | ports                          | dir
// ---------+--------------------------------+-----
// input    | in_valid, in_stall, in_item    | in
// result   | out_valid, out_stall, out_item | out
//
// One byte per cycle while in_stall is low; each item's result is registered in the cycle after accept.
// Throughput is set by the single parse-state update loop (phase, counters).
// in_stall is high only while a held result is stalled downstream.
// Synchronous active-low reset clears the parse state and the result valid.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tlv_record_stream_parser_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tlvrsp_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tlvrsp_pkg::out_item_t out_item
);

  tlvrsp_pkg::phase_t                phase_r, phase_nxt;
  logic [tlvrsp_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [7:0]                        left_r, left_nxt;
  logic [tlvrsp_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [tlvrsp_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [tlvrsp_pkg::USED_W-1:0]     size_r, size_nxt;
  logic                              out_valid_r, out_valid_nxt;
  tlvrsp_pkg::out_item_t             out_r, res;
  logic                              in_acc;

  tlvrsp_pkg::phase_t                ph;
  logic [tlvrsp_pkg::KIND_W-1:0]     cur_kind;
  logic [7:0]                        left_m1;
  logic [tlvrsp_pkg::POS_W-1:0]      pos;
  logic                              done;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign left_m1   = left_r - 8'd1;

  always_comb begin
    ph        = in_item.start_req ? tlvrsp_pkg::PH_TAG : phase_r;
    pos       = in_item.start_req ? '0 : pos_r;
    cur_kind  = in_item.start_req ? tlvrsp_pkg::KIND_NONE : kind_r;
    kind_nxt  = cur_kind;
    left_nxt  = in_item.start_req ? 8'd0 : left_r;
    idx_nxt   = in_item.start_req ? '0 : idx_r;
    size_nxt  = in_item.start_req ? '0 : size_r;
    phase_nxt = ph;
    done      = 1'b0;
    res.record_kind = tlvrsp_pkg::KIND_NONE;
    res.byte_index  = '0;
    res.byte_out    = in_item.data_byte;
    res.kept        = 1'b0;

    if (ph != tlvrsp_pkg::PH_DONE && pos >= tlvrsp_pkg::POS_W'(tlvrsp_pkg::STORE_BYTES)) begin
      phase_nxt = tlvrsp_pkg::PH_DONE;
    end

    case (phase_nxt)
      tlvrsp_pkg::PH_TAG: begin
        kind_nxt = tlvrsp_pkg::kind_of_tag(in_item.data_byte);
        if (kind_nxt == tlvrsp_pkg::KIND_NONE) begin
          phase_nxt = tlvrsp_pkg::PH_DONE;
        end else begin
          res.record_kind = kind_nxt;
          res.kept        = 1'b1;
          idx_nxt         = tlvrsp_pkg::IDX_W'(1);
          phase_nxt       = tlvrsp_pkg::PH_LEN;
        end
      end
      tlvrsp_pkg::PH_LEN: begin
        res.record_kind = cur_kind;
        res.kept        = 1'b1;
        res.byte_index  = tlvrsp_pkg::IDX_W'(1);
        idx_nxt         = tlvrsp_pkg::IDX_W'(2);
        left_nxt        = in_item.data_byte;
        size_nxt        = tlvrsp_pkg::USED_W'(pos) + tlvrsp_pkg::USED_W'(in_item.data_byte)
                          + tlvrsp_pkg::USED_W'(1);
        phase_nxt       = (in_item.data_byte == 8'd0) ? tlvrsp_pkg::PH_TAG
                                                      : tlvrsp_pkg::PH_VAL;
      end
      tlvrsp_pkg::PH_VAL: begin
        res.record_kind = cur_kind;
        res.kept        = 1'b1;
        res.byte_index  = idx_r;
        idx_nxt         = idx_r + tlvrsp_pkg::IDX_W'(1);
        left_nxt        = left_m1;
        if (left_m1 == 8'd0) begin
          phase_nxt = tlvrsp_pkg::PH_TAG;
        end
      end
      default: begin
        phase_nxt = tlvrsp_pkg::PH_DONE;
      end
    endcase

    done = (phase_nxt == tlvrsp_pkg::PH_DONE);
    if (done) begin
      res.record_kind = tlvrsp_pkg::KIND_NONE;
      res.byte_index  = '0;
      res.kept        = 1'b0;
      kind_nxt        = tlvrsp_pkg::KIND_NONE;
    end
    res.done_res  = done;
    res.used_size = size_nxt;

    pos_nxt = (pos < tlvrsp_pkg::POS_W'(tlvrsp_pkg::STORE_BYTES))
              ? pos + tlvrsp_pkg::POS_W'(1) : pos;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tlvrsp_pkg::PH_TAG;
      kind_r      <= tlvrsp_pkg::KIND_NONE;
      left_r      <= 8'd0;
      pos_r       <= '0;
      idx_r       <= '0;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        left_r  <= left_nxt;
        pos_r   <= pos_nxt;
        idx_r   <= idx_nxt;
        size_r  <= size_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res;
    end
  end

  `ASSERT_IMPLY(a_done_not_kept, clk, rst_n, out_valid_r && out_r.done_res,
                !out_r.kept && out_r.record_kind == tlvrsp_pkg::KIND_NONE)
  `ASSERT_IMPLY(a_kept_has_kind, clk, rst_n, out_valid_r && out_r.kept,
                out_r.record_kind != tlvrsp_pkg::KIND_NONE)
  `ASSERT_NEXT(a_done_sticky, clk, rst_n,
               in_acc && !in_item.start_req && phase_r == tlvrsp_pkg::PH_DONE,
               out_r.done_res && phase_r == tlvrsp_pkg::PH_DONE)
  `ASSERT_IMPLY(a_pos_bound, clk, rst_n, 1'b1,
                pos_r <= tlvrsp_pkg::POS_W'(tlvrsp_pkg::STORE_BYTES))
  `ASSERT_IMPLY(a_val_has_bytes, clk, rst_n, phase_r == tlvrsp_pkg::PH_VAL, left_r != 8'd0)

endmodule

/* test/testbench.sv */
// ---------------------------------------------------------------------------
// TLV record stream parser testbench
// Streams record images one byte per item into the parser and checks every
// labeled byte against an in-bench parse of the same stream. The stimulus
// covers each tag kind, zero-length records, end and unknown tags, bytes
// after the end, restarts in mid-record and images that run past the store
// end. Both sides idle at random.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         ITEM_TARGET = 1300;
  localparam int         IDLE_LIMIT  = 2000;
  localparam int         DRAIN_WAIT  = 10;
  localparam logic [7:0] TAG_END     = 8'h00;

  typedef struct {
    tlvrsp_pkg::in_item_t item;
    int                   gap;
    bit                   hold;
  } pending_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  tlvrsp_pkg::in_item_t  in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  tlvrsp_pkg::out_item_t out_item;

  pending_byte_t         pending_bytes[$];
  tlvrsp_pkg::out_item_t byte_labels_due[$];

  int tx_wait = -1;
  bit tx_busy;
  int tx_calm = 0;
  int rx_calm = 0;
  int rx_stall_left = 0;
  int idle_cycles = 0;

  int bytes_sent = 0;
  int labels_checked = 0;
  int kept_seen = 0;
  int done_seen = 0;
  int images_built = 0;
  int fills_built = 0;
  int mismatches = 0;

  // parse state of the in-bench model
  tlvrsp_pkg::phase_t            ph;
  logic [tlvrsp_pkg::KIND_W-1:0] cur_kind;
  logic [8:0]                    left_in_record;
  int                            offset;
  logic [8:0]                    idx_in_record;
  logic [tlvrsp_pkg::USED_W-1:0] used_bytes;

  tlv_record_stream_parser_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void clear_parse();
    ph             = tlvrsp_pkg::PH_TAG;
    cur_kind       = tlvrsp_pkg::KIND_NONE;
    left_in_record = '0;
    offset         = 0;
    idx_in_record  = '0;
    used_bytes     = '0;
  endfunction

  function automatic tlvrsp_pkg::out_item_t parse_byte(input tlvrsp_pkg::in_item_t it);
    tlvrsp_pkg::out_item_t         r;
    logic [7:0]                    b;
    logic [tlvrsp_pkg::KIND_W-1:0] k;
    b = it.data_byte;
    r = '0;
    r.byte_out = b;
    if (it.start_req) clear_parse();
    if (ph != tlvrsp_pkg::PH_DONE && offset >= tlvrsp_pkg::STORE_BYTES)
      ph = tlvrsp_pkg::PH_DONE;
    case (ph)
      tlvrsp_pkg::PH_TAG: begin
        case (b)
          tlvrsp_pkg::TAG_MAC1:    k = tlvrsp_pkg::KIND_MAC1;
          tlvrsp_pkg::TAG_MAC2:    k = tlvrsp_pkg::KIND_MAC2;
          tlvrsp_pkg::TAG_SW_ID:   k = tlvrsp_pkg::KIND_SW_ID;
          tlvrsp_pkg::TAG_BKLIGHT: k = tlvrsp_pkg::KIND_BKLIGHT;
          tlvrsp_pkg::TAG_DISPLAY: k = tlvrsp_pkg::KIND_DISPLAY;
          tlvrsp_pkg::TAG_LOGO:    k = tlvrsp_pkg::KIND_LOGO;
          default:                 k = tlvrsp_pkg::KIND_NONE;
        endcase
        cur_kind = k;
        if (k == tlvrsp_pkg::KIND_NONE) begin
          ph = tlvrsp_pkg::PH_DONE;
        end else begin
          r.record_kind = k;
          r.kept        = 1'b1;
          idx_in_record = 9'd1;
          ph            = tlvrsp_pkg::PH_LEN;
        end
      end
      tlvrsp_pkg::PH_LEN: begin
        r.record_kind  = cur_kind;
        r.kept         = 1'b1;
        r.byte_index   = 9'd1;
        idx_in_record  = 9'd2;
        left_in_record = {1'b0, b};
        // offset is the length byte, the tag sat one before
        used_bytes     = tlvrsp_pkg::USED_W'(offset + 1 + b);
        ph             = (b == 8'd0) ? tlvrsp_pkg::PH_TAG : tlvrsp_pkg::PH_VAL;
      end
      tlvrsp_pkg::PH_VAL: begin
        r.record_kind  = cur_kind;
        r.kept         = 1'b1;
        r.byte_index   = idx_in_record;
        idx_in_record  = idx_in_record + 9'd1;
        left_in_record = left_in_record - 9'd1;
        if (left_in_record == '0) ph = tlvrsp_pkg::PH_TAG;
      end
      default: ph = tlvrsp_pkg::PH_DONE;
    endcase
    if (ph == tlvrsp_pkg::PH_DONE) begin
      r.record_kind = tlvrsp_pkg::KIND_NONE;
      r.byte_index  = '0;
      r.kept        = 1'b0;
      r.done_res    = 1'b1;
      cur_kind      = tlvrsp_pkg::KIND_NONE;
    end
    if (offset < tlvrsp_pkg::STORE_BYTES) offset++;
    r.used_size = used_bytes;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_label(input tlvrsp_pkg::out_item_t got);
    tlvrsp_pkg::out_item_t want;
    if (byte_labels_due.size() == 0) begin
      report_mismatch($sformatf("label for byte %02h with none due", got.byte_out));
      return;
    end
    want = byte_labels_due.pop_front();
    if (got.record_kind !== want.record_kind)
      report_mismatch($sformatf("label %0d record_kind %0d, want %0d",
                                labels_checked, got.record_kind, want.record_kind));
    if (got.byte_index !== want.byte_index)
      report_mismatch($sformatf("label %0d byte_index %0d, want %0d",
                                labels_checked, got.byte_index, want.byte_index));
    if (got.byte_out !== want.byte_out)
      report_mismatch($sformatf("label %0d byte_out %02h, want %02h",
                                labels_checked, got.byte_out, want.byte_out));
    if (got.kept !== want.kept)
      report_mismatch($sformatf("label %0d kept %b, want %b",
                                labels_checked, got.kept, want.kept));
    if (got.done_res !== want.done_res)
      report_mismatch($sformatf("label %0d done_res %b, want %b",
                                labels_checked, got.done_res, want.done_res));
    if (got.used_size !== want.used_size)
      report_mismatch($sformatf("label %0d used_size %0d, want %0d",
                                labels_checked, got.used_size, want.used_size));
  endtask

  // idle length per item, with occasional stretches of none
  function automatic int draw_delay(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [7:0] pick_tag();
    case ($urandom_range(0, 5))
      0:       return tlvrsp_pkg::TAG_MAC1;
      1:       return tlvrsp_pkg::TAG_MAC2;
      2:       return tlvrsp_pkg::TAG_SW_ID;
      3:       return tlvrsp_pkg::TAG_BKLIGHT;
      4:       return tlvrsp_pkg::TAG_DISPLAY;
      default: return tlvrsp_pkg::TAG_LOGO;
    endcase
  endfunction

  function automatic logic [7:0] pick_unknown_tag();
    logic [7:0] t;
    do t = 8'($urandom_range(1, 255));
    while (t inside {tlvrsp_pkg::TAG_MAC1, tlvrsp_pkg::TAG_MAC2, tlvrsp_pkg::TAG_SW_ID,
                     tlvrsp_pkg::TAG_BKLIGHT, tlvrsp_pkg::TAG_DISPLAY,
                     tlvrsp_pkg::TAG_LOGO});
    return t;
  endfunction

  task automatic add_byte(input logic [7:0] b, input bit s, input bit hold);
    pending_byte_t p;
    p.item.data_byte = b;
    p.item.start_req = s;
    p.gap            = draw_delay(tx_calm);
    p.hold           = hold;
    pending_bytes.push_back(p);
  endtask

  task automatic push_record(ref logic [7:0] img[$], input logic [7:0] tag, input int len);
    img.push_back(tag);
    img.push_back(8'(len));
    repeat (len) img.push_back(8'($urandom));
  endtask

  task automatic build_image(input bit fill);
    logic [7:0] img[$];
    int         off, len, nrec, cut, ending;
    bit         hold;
    off  = 0;
    hold = ($urandom_range(0, 11) == 0);
    if (fill) begin
      // records up to a tag at offset 254, then one running past the store
      while (off < 254) begin
        len = $urandom_range(0, 40);
        if (len > 252 - off) len = 252 - off;
        if (off + 2 + len == 253) len = 252 - off;
        push_record(img, pick_tag(), len);
        off += 2 + len;
      end
      img.push_back(pick_tag());
      img.push_back(fills_built == 0 ? 8'hFF : 8'($urandom));
      repeat ($urandom_range(2, 12)) img.push_back(8'($urandom));
      fills_built++;
    end else begin
      nrec = $urandom_range(1, 6);
      repeat (nrec) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        push_record(img, pick_tag(), len);
      end
      ending = $urandom_range(0, 4);
      if (ending < 2) img.push_back(TAG_END);
      else if (ending < 4) img.push_back(pick_unknown_tag());
      if (ending < 4) repeat ($urandom_range(0, 3)) img.push_back(8'($urandom));
      // broken image: next start lands mid-record
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, img.size());
        while (img.size() > cut) void'(img.pop_back());
      end
    end
    foreach (img[i]) add_byte(img[i], i == 0, hold && i == 0);
    images_built++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = -1;
    end else begin
      tx_busy = in_valid;
      if (in_valid && !in_stall) begin
        bytes_sent++;
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (pending_bytes.size() != 0) begin
          if (tx_wait < 0) tx_wait = pending_bytes[0].gap;
          if (tx_wait > 0) begin
            tx_wait--;
            in_valid <= 1'b0;
          end else if (pending_bytes[0].hold && bytes_sent != labels_checked) begin
            in_valid <= 1'b0;
          end else begin
            in_item  <= pending_bytes[0].item;
            in_valid <= 1'b1;
            void'(pending_bytes.pop_front());
            tx_wait = -1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predicts on input accept, checks on result accept
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_stall_left = 0;
      clear_parse();
    end else begin
      if (in_valid && !in_stall) byte_labels_due.push_back(parse_byte(in_item));
      if (out_valid && !out_stall) begin
        check_label(out_item);
        if (out_item.kept) kept_seen++;
        if (out_item.done_res) done_seen++;
        labels_checked++;
        rx_stall_left = draw_delay(rx_calm);
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    // directed: every tag, zero length, end tag, bytes after end, restarts
    add_byte(tlvrsp_pkg::TAG_MAC1, 1'b1, 1'b0);
    add_byte(8'd2, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(tlvrsp_pkg::TAG_MAC2, 1'b0, 1'b0);
    add_byte(8'd0, 1'b0, 1'b0);
    add_byte(tlvrsp_pkg::TAG_SW_ID, 1'b0, 1'b0);
    add_byte(8'd1, 1'b0, 1'b0);
    add_byte(8'hA5, 1'b0, 1'b0);
    add_byte(tlvrsp_pkg::TAG_BKLIGHT, 1'b0, 1'b0);
    add_byte(8'd1, 1'b0, 1'b0);
    add_byte(8'h5A, 1'b0, 1'b0);
    add_byte(tlvrsp_pkg::TAG_DISPLAY, 1'b0, 1'b0);
    add_byte(8'd1, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(tlvrsp_pkg::TAG_LOGO, 1'b0, 1'b0);
    add_byte(8'd1, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b0, 1'b0);
    add_byte(TAG_END, 1'b0, 1'b0);
    add_byte(tlvrsp_pkg::TAG_MAC1, 1'b0, 1'b0);
    add_byte(tlvrsp_pkg::TAG_LOGO, 1'b1, 1'b1);
    add_byte(8'd3, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b0, 1'b0);
    add_byte(8'h55, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    build_image(1'b1);
    build_image(1'b1);
    while (pending_bytes.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 59);
      if (pick == 0) begin
        build_image(1'b1);
      end else if (pick < 5) begin
        repeat ($urandom_range(1, 12))
          add_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0);
      end else begin
        build_image(1'b0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (!(pending_bytes.size() == 0 && !in_valid && bytes_sent == labels_checked));
    repeat (DRAIN_WAIT) @(posedge clk);
    if (byte_labels_due.size() != 0)
      report_mismatch($sformatf("%0d labels never arrived", byte_labels_due.size()));

    $display("Sent %0d bytes in %0d images, %0d of them filled past the store end.",
             bytes_sent, images_built, fills_built);
    $display("Checked %0d labels: %0d kept, %0d after parsing ended, %0d mismatches.",
             labels_checked, kept_seen, done_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* tlv_record_stream_parser_unit.f */
+incdir+rtl/core
rtl/core/tlvrsp_pkg.sv
rtl/core/tlv_record_stream_parser_unit.sv
test/testbench.sv
